[design/pidc_pkg.sv]
// Shared types and constants of the PID controller with output and integral clamps.
// Used by every module of the block; depends on nothing.
package pidc_pkg;

	localparam int SAMPLE_WIDTH_DEF   = 16;
	localparam int GAIN_FRAC_BITS_DEF = 16;

	localparam int GAIN_W   = 32;
	localparam int TARGET_W = 16;
	localparam int DRIVE_W  = 32;
	localparam int BOUND_W  = 31;
	localparam int SUM_W    = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic OP_COMPUTE = 1'b0;
	localparam logic OP_CLEAR   = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FLOOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CEILING  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WINDUP   = 3'd6;

	localparam logic [GAIN_W-1:0]   GAIN_RST    = 32'sd0;
	localparam logic [TARGET_W-1:0] TARGET_RST  = 16'sd0;
	localparam logic [DRIVE_W-1:0]  FLOOR_RST   = -32'sd32768;
	localparam logic [DRIVE_W-1:0]  CEILING_RST = 32'sd32767;
	localparam logic [BOUND_W-1:0]  WINDUP_RST  = 31'd65535;

	typedef struct packed {
		logic [GAIN_W-1:0]   gain_p;
		logic [GAIN_W-1:0]   gain_i;
		logic [GAIN_W-1:0]   gain_d;
		logic [TARGET_W-1:0] target;
		logic [DRIVE_W-1:0]  drive_floor;
		logic [DRIVE_W-1:0]  drive_ceiling;
		logic [BOUND_W-1:0]  windup_bound;
	} cfg_t;

endpackage

[design/pidc_cfg_regs.sv]
// Configuration register file of the PID controller.
// Depends on pidc_pkg for the register indexes, reset values and cfg_t.
module pidc_cfg_regs
	import pidc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= GAIN_RST;
			cfg_q.gain_i        <= GAIN_RST;
			cfg_q.gain_d        <= GAIN_RST;
			cfg_q.target        <= TARGET_RST;
			cfg_q.drive_floor   <= FLOOR_RST;
			cfg_q.drive_ceiling <= CEILING_RST;
			cfg_q.windup_bound  <= WINDUP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN_P:  cfg_q.gain_p        <= cfg_data;
				REG_GAIN_I:  cfg_q.gain_i        <= cfg_data;
				REG_GAIN_D:  cfg_q.gain_d        <= cfg_data;
				REG_TARGET:  cfg_q.target        <= cfg_data[TARGET_W-1:0];
				REG_FLOOR:   cfg_q.drive_floor   <= cfg_data;
				REG_CEILING: cfg_q.drive_ceiling <= cfg_data;
				REG_WINDUP:  cfg_q.windup_bound  <= cfg_data[BOUND_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/pidc_error_stage.sv]
// Input register, error forming, clamped integral and last-error state of the controller.
// Depends on pidc_pkg; feeds the multiply-and-clamp pipeline in pidc_mac.
module pidc_error_stage
	import pidc_pkg::*;
#(
	parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
	localparam int EW = ((SAMPLE_WIDTH > TARGET_W) ? SAMPLE_WIDTH : TARGET_W) + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic [SAMPLE_WIDTH-1:0] measured,
	input  logic                    take,
	output logic                    valid_s2,
	output logic signed [EW-1:0]    err_s2,
	output logic signed [SUM_W-1:0] integ_s2,
	output logic signed [EW:0]      diff_s2
);

	logic                    v_s1;
	logic                    opcode_s1;
	logic [SAMPLE_WIDTH-1:0] meas_s1;
	logic                    v_s2;
	logic signed [SUM_W-1:0] error_sum_q;
	logic signed [EW-1:0]    prev_err_q;

	logic en_s1, en_s2;
	logic signed [EW-1:0]    err;
	logic signed [EW:0]      diff;
	logic signed [SUM_W:0]   integ_raw;
	logic signed [SUM_W:0]   bound_pos;
	logic signed [SUM_W:0]   bound_neg;
	logic signed [SUM_W-1:0] integ;

	assign en_s2    = !v_s2 || take;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;

	always_comb begin
		err = $signed({{(EW-TARGET_W){cfg.target[TARGET_W-1]}}, cfg.target})
		    - $signed({{(EW-SAMPLE_WIDTH){meas_s1[SAMPLE_WIDTH-1]}}, meas_s1});
		diff = $signed({err[EW-1], err}) - $signed({prev_err_q[EW-1], prev_err_q});
		integ_raw = $signed({error_sum_q[SUM_W-1], error_sum_q})
		          + $signed({{(SUM_W+1-EW){err[EW-1]}}, err});
		bound_pos = $signed({2'b00, cfg.windup_bound});
		bound_neg = -bound_pos;
		// The bound is at most 2^31-1, so every clamped value fits the 32-bit integral.
		if (integ_raw > bound_pos) begin
			integ = bound_pos[SUM_W-1:0];
		end else if (integ_raw < bound_neg) begin
			integ = bound_neg[SUM_W-1:0];
		end else begin
			integ = integ_raw[SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			error_sum_q <= '0;
			prev_err_q  <= '0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				// A clear beat updates the state here and leaves no result behind it.
				v_s2 <= v_s1 && (opcode_s1 == OP_COMPUTE);
				if (v_s1) begin
					if (opcode_s1 == OP_CLEAR) begin
						error_sum_q <= '0;
						prev_err_q  <= '0;
					end else begin
						error_sum_q <= integ;
						prev_err_q  <= err;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			opcode_s1 <= opcode;
			meas_s1   <= measured;
		end
		if (en_s2) begin
			err_s2   <= err;
			integ_s2 <= integ;
			diff_s2  <= diff;
		end
	end

	assign valid_s2 = v_s2;

endmodule

[design/pidc_mac.sv]
// Gain products, exact sum, output clamp and truncation of the controller, ending in
// the result register. Depends on pidc_pkg and on operands from pidc_error_stage.
module pidc_mac
	import pidc_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
	localparam int EW = ((SAMPLE_WIDTH > TARGET_W) ? SAMPLE_WIDTH : TARGET_W) + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_t                    cfg,
	input  logic                    valid_s2,
	input  logic signed [EW-1:0]    err_s2,
	input  logic signed [SUM_W-1:0] integ_s2,
	input  logic signed [EW:0]      diff_s2,
	output logic                    take,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DRIVE_W-1:0]      drive
);

	localparam int PW = GAIN_W + EW;
	localparam int IW = GAIN_W + SUM_W;
	localparam int DW = GAIN_W + EW + 1;
	localparam int MW = (DW > IW) ? DW : IW;
	localparam int AW = MW + 2;
	localparam logic [AW-1:0] FRAC_MASK = (AW'(1) << GAIN_FRAC_BITS) - AW'(1);

	logic                    v_s3, v_s4, out_valid_q;
	logic signed [PW-1:0]    prod_p_s3;
	logic signed [IW-1:0]    prod_i_s3;
	logic signed [DW-1:0]    prod_d_s3;
	logic signed [AW-1:0]    sum_s4;
	logic [DRIVE_W-1:0]      drive_q;

	logic en_out, en_s4, en_s3;
	logic signed [AW-1:0]      ceil_scaled;
	logic signed [AW-1:0]      floor_scaled;
	logic signed [AW-1:0]      rounded;
	logic [DRIVE_W-1:0]        drive_next;

	assign en_out = !out_valid_q || !out_stall;
	assign en_s4  = !v_s4 || en_out;
	assign en_s3  = !v_s3 || en_s4;
	assign take   = en_s3;

	always_comb begin
		ceil_scaled = $signed({{(AW-DRIVE_W){cfg.drive_ceiling[DRIVE_W-1]}},
		                      cfg.drive_ceiling}) <<< GAIN_FRAC_BITS;
		floor_scaled = $signed({{(AW-DRIVE_W){cfg.drive_floor[DRIVE_W-1]}},
		                       cfg.drive_floor}) <<< GAIN_FRAC_BITS;
		// Adding the fraction mask to a negative sum makes the arithmetic shift
		// truncate toward zero rather than toward minus infinity.
		rounded = sum_s4 + $signed(sum_s4[AW-1] ? FRAC_MASK : AW'(0));
		if (sum_s4 > ceil_scaled) begin
			drive_next = cfg.drive_ceiling;
		end else if (sum_s4 < floor_scaled) begin
			drive_next = cfg.drive_floor;
		end else begin
			drive_next = rounded[GAIN_FRAC_BITS +: DRIVE_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en_s3) begin
				v_s3 <= valid_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_out) begin
				out_valid_q <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3) begin
			prod_p_s3 <= $signed(cfg.gain_p) * err_s2;
			prod_i_s3 <= $signed(cfg.gain_i) * integ_s2;
			prod_d_s3 <= $signed(cfg.gain_d) * diff_s2;
		end
		if (en_s4) begin
			sum_s4 <= AW'(prod_p_s3) + AW'(prod_i_s3) + AW'(prod_d_s3);
		end
		if (en_out) begin
			drive_q <= drive_next;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

[design/pid_controller_with_clamps.sv]
// Top level of the positional PID controller with integral and output clamps.
// Depends on pidc_pkg, pidc_cfg_regs, pidc_error_stage and pidc_mac.
//
// Use: gains, setpoint, drive limits and the integral bound are written through
// cfg_we/cfg_index/cfg_data while no beat is in flight. Each input beat carries an
// opcode and a measured sample and is taken at a clock edge where in_valid is high
// and in_stall is low. A compute beat yields one drive beat; a clear beat zeroes the
// integral and the last error and yields nothing.
// A drive reaches out_valid through the input register, operand register, product
// register, sum register and result register after its input beat is taken.
// Throughput: one beat per cycle while nothing stalls, set by the update of the
// integral and last error, which every stage after it does not feed back into.
// When out_stall is high a full result register holds; stages upstream keep filling
// their empty slots, and in_stall rises only once every stage holds a beat.
// Reset clears all valid flags, the integral and the last error, and loads the
// register defaults: zero gains and setpoint, drive range -32768 to 32767 and an
// integral bound of 65535.
module pid_controller_with_clamps
	import pidc_pkg::*;
#(
	parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    opcode,
	input  logic [SAMPLE_WIDTH-1:0] measured,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [DRIVE_W-1:0]      drive
);

	localparam int EW = ((SAMPLE_WIDTH > TARGET_W) ? SAMPLE_WIDTH : TARGET_W) + 1;

	cfg_t                    cfg;
	logic                    take;
	logic                    valid_s2;
	logic signed [EW-1:0]    err_s2;
	logic signed [SUM_W-1:0] integ_s2;
	logic signed [EW:0]      diff_s2;

	pidc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidc_error_stage #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_err (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.opcode   (opcode),
		.measured (measured),
		.take     (take),
		.valid_s2 (valid_s2),
		.err_s2   (err_s2),
		.integ_s2 (integ_s2),
		.diff_s2  (diff_s2)
	);

	pidc_mac #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.valid_s2  (valid_s2),
		.err_s2    (err_s2),
		.integ_s2  (integ_s2),
		.diff_s2   (diff_s2),
		.take      (take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

endmodule

[bench/testbench.sv]
// Self-checking bench for pid_controller_with_clamps: directed and random sample beats
// against a cycle-free model of the clamped PID update. Depends on pidc_pkg and the RTL.
module testbench;
	import pidc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int                   LATENCY   = 5;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
	localparam int                   PHASES    = 10;
	localparam int                   PHASE_LEN = 68;
	localparam int                   SQUEEZE_PHASE = 3;

	class drive_scoreboard;
		longint gain_p, gain_i, gain_d, setpoint, floor_lim, ceil_lim, bound;
		logic signed [SUM_W-1:0]          integral;
		logic signed [SAMPLE_WIDTH_DEF:0] held_error;
		logic [DRIVE_W-1:0]               expected_drive[$];
		int                               errors;
		int                               checked;

		function new();
			gain_p = 0;
			gain_i = 0;
			gain_d = 0;
			setpoint = 0;
			floor_lim = -32768;
			ceil_lim = 32767;
			bound = 65535;
			integral = '0;
			held_error = '0;
			errors = 0;
			checked = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_GAIN_P:  gain_p = longint'($signed(data));
				REG_GAIN_I:  gain_i = longint'($signed(data));
				REG_GAIN_D:  gain_d = longint'($signed(data));
				REG_TARGET:  setpoint = longint'($signed(data[TARGET_W-1:0]));
				REG_FLOOR:   floor_lim = longint'($signed(data));
				REG_CEILING: ceil_lim = longint'($signed(data));
				REG_WINDUP:  bound = longint'({1'b0, data[BOUND_W-1:0]});
				default: ;
			endcase
		endfunction

		// Works out the drive that an accepted beat must produce, if any.
		function void note_beat(logic op, logic [SAMPLE_WIDTH_DEF-1:0] sample);
			longint err, sum, prev, acc, scale, res;
			if (op == OP_CLEAR) begin
				integral = '0;
				held_error = '0;
				return;
			end
			err = setpoint - longint'($signed(sample));
			sum = longint'(integral) + err;
			if (sum > bound)
				sum = bound;
			else if (sum < -bound)
				sum = -bound;
			integral = sum[SUM_W-1:0];
			prev = longint'(held_error);
			// The products stay well inside 64 bits, so no saturation is needed.
			acc = gain_p * err + gain_i * sum + gain_d * (err - prev);
			held_error = err[SAMPLE_WIDTH_DEF:0];
			scale = longint'(1) << GAIN_FRAC_BITS_DEF;
			// The clamps are tested on the exact sum, the ceiling first.
			if (acc > ceil_lim * scale)
				res = ceil_lim;
			else if (acc < floor_lim * scale)
				res = floor_lim;
			else if (acc >= 0)
				res = acc >>> GAIN_FRAC_BITS_DEF;
			else
				res = -((-acc) >>> GAIN_FRAC_BITS_DEF);
			expected_drive.push_back(res[DRIVE_W-1:0]);
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			errors++;
		endtask

		task check_drive(logic [DRIVE_W-1:0] got);
			logic [DRIVE_W-1:0] want;
			if (expected_drive.size() == 0) begin
				report_mismatch($sformatf("drive %0d with no sample waiting", $signed(got)));
				return;
			end
			want = expected_drive.pop_front();
			checked++;
			if (got !== want)
				report_mismatch($sformatf("drive %0d, expected %0d", $signed(got),
					$signed(want)));
		endtask
	endclass

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [CFG_IDX_W-1:0]        cfg_index;
	logic [CFG_DATA_W-1:0]       cfg_data;
	logic                        in_valid;
	logic                        in_stall;
	logic                        opcode;
	logic [SAMPLE_WIDTH_DEF-1:0] measured;
	logic                        out_valid;
	logic                        out_stall;
	logic [DRIVE_W-1:0]          drive;

	drive_scoreboard sb = new();
	bit sender_steady;
	bit hold_off;
	int beats, clears, settings_used;

	pid_controller_with_clamps u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.measured  (measured),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.drive     (drive)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	// Mostly no wait, sometimes a short one, now and then a long one.
	function int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	function logic [GAIN_W-1:0] random_gain();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
			default: return $urandom;
		endcase
	endfunction

	function cfg_t random_settings();
		cfg_t s;
		logic [DRIVE_W-1:0] base;
		s.gain_p = random_gain();
		s.gain_i = random_gain();
		s.gain_d = random_gain();
		case ($urandom_range(0, 3))
			0: s.target = 16'h8000;
			1: s.target = 16'h7FFF;
			default: s.target = TARGET_W'($urandom);
		endcase
		case ($urandom_range(0, 4))
			0: begin
				s.drive_floor = 32'h8000_0000;
				s.drive_ceiling = 32'h7FFF_FFFF;
			end
			1: begin
				s.drive_floor = -$urandom_range(0, 100000);
				s.drive_ceiling = $urandom_range(0, 100000);
			end
			2: begin
				s.drive_floor = $urandom;
				s.drive_ceiling = $urandom;
			end
			3: begin
				// Floor above the ceiling.
				base = $urandom_range(0, 80) - 40;
				s.drive_floor = base;
				s.drive_ceiling = base - $urandom_range(1, 20);
			end
			default: begin
				s.drive_floor = -$urandom_range(0, 50);
				s.drive_ceiling = $urandom_range(0, 50);
			end
		endcase
		case ($urandom_range(0, 3))
			0: s.windup_bound = '0;
			1: s.windup_bound = 31'h7FFF_FFFF;
			2: s.windup_bound = BOUND_W'($urandom_range(0, 300000));
			default: s.windup_bound = BOUND_W'($urandom);
		endcase
		return s;
	endfunction

	// The write enable stays high across back-to-back writes.
	task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
	endtask

	task apply_settings(input cfg_t s, input bit spare_write);
		if (spare_write)
			write_reg(REG_SPARE, $urandom);
		write_reg(REG_GAIN_P, s.gain_p);
		write_reg(REG_GAIN_I, s.gain_i);
		write_reg(REG_GAIN_D, s.gain_d);
		write_reg(REG_TARGET, {{(CFG_DATA_W-TARGET_W){s.target[TARGET_W-1]}}, s.target});
		write_reg(REG_FLOOR, s.drive_floor);
		write_reg(REG_CEILING, s.drive_ceiling);
		write_reg(REG_WINDUP, {1'b0, s.windup_bound});
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task send_beat(input logic op, input logic [SAMPLE_WIDTH_DEF-1:0] sample);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		measured <= sample;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_beat(op, sample);
		beats++;
		if (op == OP_CLEAR)
			clears++;
	endtask

	// A clear leaves nothing to wait for, so the pipeline is given time to drain.
	task settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_drive.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	// Receiver: checks every drive beat and stalls at random.
	initial begin
		int stall_left;
		int gap;
		bit held;
		bit steady;
		stall_left = 0;
		held = 1'b0;
		steady = 1'b0;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall)
				sb.check_drive(drive);
			if (hold_off && !held) begin
				held = 1'b1;
				stall_left = 60;
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else if (steady) begin
				out_stall <= 1'b0;
			end else begin
				gap = pick_gap();
				out_stall <= (gap > 0);
				stall_left = (gap > 0) ? gap - 1 : 0;
			end
			if ($urandom_range(0, 199) == 0)
				steady = !steady;
		end
	end

	initial begin
		cfg_t s;
		int bias;
		int r;
		logic [SAMPLE_WIDTH_DEF-1:0] sample;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		in_valid <= 1'b0;
		opcode <= OP_COMPUTE;
		measured <= '0;
		sender_steady = 1'b0;
		hold_off = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: zero gains give a zero drive.
		send_beat(OP_COMPUTE, 16'h0000);
		send_beat(OP_COMPUTE, 16'h8000);
		settle();

		// Full-scale positive errors driving the integral into its bound.
		s = '{gain_p: 32'h0001_0000, gain_i: 32'h0001_0000, gain_d: 32'hFFFF_8000,
			target: 16'h7FFF, drive_floor: 32'h8000_0000, drive_ceiling: 32'h7FFF_FFFF,
			windup_bound: 31'd100000};
		apply_settings(s, 1'b1);
		send_beat(OP_COMPUTE, 16'h8000);
		send_beat(OP_COMPUTE, 16'h8000);
		send_beat(OP_COMPUTE, 16'h7FFF);
		send_beat(OP_CLEAR, 16'h1234);
		send_beat(OP_COMPUTE, 16'h7FFF);
		send_beat(OP_COMPUTE, 16'h8000);
		settle();

		// Extreme gains, no integral room, and the floor above the ceiling.
		s = '{gain_p: 32'h7FFF_FFFF, gain_i: 32'h8000_0000, gain_d: 32'h7FFF_FFFF,
			target: 16'h8000, drive_floor: 32'd100, drive_ceiling: -32'sd100,
			windup_bound: 31'd0};
		apply_settings(s, 1'b0);
		send_beat(OP_COMPUTE, 16'h7FFF);
		send_beat(OP_COMPUTE, 16'h8000);
		send_beat(OP_CLEAR, 16'hFFFF);
		send_beat(OP_COMPUTE, 16'h0000);
		settle();

		// Half gain: fractions are cut toward zero on both signs.
		s = '{gain_p: 32'h0000_8000, gain_i: 32'h0, gain_d: 32'h0, target: 16'h0,
			drive_floor: -32'sd32768, drive_ceiling: 32'd32767,
			windup_bound: 31'h7FFF_FFFF};
		apply_settings(s, 1'b0);
		send_beat(OP_COMPUTE, 16'h0001);
		send_beat(OP_COMPUTE, 16'hFFFF);
		send_beat(OP_COMPUTE, 16'h0003);
		send_beat(OP_COMPUTE, 16'hFFFD);
		settle();

		// Sum a hair above the ceiling, which lies below the floor: the exact
		// comparison picks the ceiling where a truncated one would pick the floor.
		s = '{gain_p: 32'h0001_0001, gain_i: 32'h0, gain_d: 32'h0, target: 16'd4,
			drive_floor: 32'd5, drive_ceiling: 32'd4, windup_bound: 31'd65535};
		apply_settings(s, 1'b0);
		send_beat(OP_COMPUTE, 16'h0000);
		send_beat(OP_COMPUTE, 16'h0004);

		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			apply_settings(random_settings(), $urandom_range(0, 3) == 0);
			sender_steady = ($urandom_range(0, 3) == 0);
			if (phase == SQUEEZE_PHASE) begin
				sender_steady = 1'b1;
				hold_off = 1'b1;
			end
			bias = $urandom_range(0, 1) ? 1 : -1;
			for (int k = 0; k < PHASE_LEN; k++) begin
				// Runs of same-signed errors wind the integral up against its bound.
				if ($urandom_range(0, 29) == 0)
					bias = -bias;
				r = $urandom_range(0, 99);
				if (r < 50)
					sample = SAMPLE_WIDTH_DEF'(sb.setpoint - bias * $urandom_range(0, 400));
				else if (r < 85)
					sample = SAMPLE_WIDTH_DEF'($urandom);
				else if (r < 90)
					sample = 16'h8000;
				else if (r < 95)
					sample = 16'h7FFF;
				else
					sample = SAMPLE_WIDTH_DEF'(sb.setpoint);
				send_beat(($urandom_range(0, 11) == 0) ? OP_CLEAR : OP_COMPUTE, sample);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.expected_drive.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
		$display("Covered %0d sample beats (%0d clears) under %0d register settings.",
			beats, clears, settings_used);
		$display("%0d drive values compared, %0d mismatches.", sb.checked, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
